>>> hdl/emk_pkg.sv
// Shared types and constants for the 3x3 edge mask pipeline.
`timescale 1ns / 1ps

package emk_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_PIX    = 9;
    localparam int PIX_MAX    = 2**PIX_W - 1;
    localparam int COEF_W     = 16;
    localparam int COEF_ROW_W = 3 * COEF_W;
    localparam int DIV_W      = 16;
    localparam int MODE_W     = 3;

    // Magnitude handed to the threshold stage: 0..255, or MAG_SAT for anything larger.
    localparam int MAG_W = PIX_W + 1;
    localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(PIX_MAX + 1);

    // Quotient bits resolved by the divider; larger quotients saturate.
    localparam int QUO_BITS    = PIX_W;
    localparam int CONV_DEPTH  = 4 + QUO_BITS;
    localparam int FIXED_DEPTH = 3;
    localparam int FIX_DLY     = CONV_DEPTH - FIXED_DEPTH;

    localparam logic [MODE_W-1:0] MODE_CONV         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOBEL        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROBERTS      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LAPLACE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MORPHO       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CARTOON      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PREWITT      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_HALF_PREWITT = 3'd7;

    // Configuration register indexes; the last one has no register behind it.
    typedef enum logic [2:0] {
        REG_MODE,
        REG_LOW_THRESHOLD,
        REG_HIGH_THRESHOLD,
        REG_COEF_TOP,
        REG_COEF_MID,
        REG_COEF_BOTTOM,
        REG_DIVISOR,
        REG_NONE
    } reg_index_t;

    // Window pixels in raster order, up_left at index 0.
    typedef logic [NUM_PIX-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [PIX_W-1:0]        low_threshold;
        logic [PIX_W-1:0]        high_threshold;
        logic [COEF_ROW_W-1:0]   coef_row_top;
        logic [COEF_ROW_W-1:0]   coef_row_mid;
        logic [COEF_ROW_W-1:0]   coef_row_bottom;
        logic signed [DIV_W-1:0] divisor;
    } cfg_t;

endpackage

>>> hdl/edge_mask_3x3_core.sv
// Top level of the 3x3 edge mask: stream ports, configuration registers and threshold.
// Pipeline: an accepted input beat passes the input register, 12 stages set by the
// product/adder tree and the 8-stage quotient pipeline, and the output register.
// Throughput: one window per cycle; the whole pipeline holds while the output beat waits.
// Reset: asynchronous active-low rst_n clears all valid bits and loads the register defaults
// (sobel mode, thresholds 0 and 255, identity kernel, divisor 1).
`timescale 1ns / 1ps

module edge_mask_3x3_core
    import emk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Nine pixels in raster order, 8 bits each, lowest first: top row left to right,
    // then middle row left to right, then bottom row left to right.
    input  logic [NUM_PIX*PIX_W-1:0] s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mask_value
    output logic [PIX_W-1:0]      m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [COEF_ROW_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    logic                en;
    logic [CONV_DEPTH:0] valid_reg, valid_next;
    win_t                win_reg;

    logic [MAG_W-1:0] conv_mag;
    logic [MAG_W-1:0] fixed_mag;
    logic [MAG_W-1:0] fix_dly_reg [FIX_DLY];
    logic [MAG_W-1:0] sel_mag;

    logic             m_tvalid_reg;
    logic [PIX_W-1:0] m_tdata_reg, m_tdata_next;

    // Every stage moves together unless a finished beat is still waiting.
    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:           cfg_next.mode            = cfg_data[MODE_W-1:0];
                REG_LOW_THRESHOLD:  cfg_next.low_threshold   = cfg_data[PIX_W-1:0];
                REG_HIGH_THRESHOLD: cfg_next.high_threshold  = cfg_data[PIX_W-1:0];
                REG_COEF_TOP:       cfg_next.coef_row_top    = cfg_data;
                REG_COEF_MID:       cfg_next.coef_row_mid    = cfg_data;
                REG_COEF_BOTTOM:    cfg_next.coef_row_bottom = cfg_data;
                REG_DIVISOR:        cfg_next.divisor         = $signed(cfg_data[DIV_W-1:0]);
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= MODE_SOBEL;
            cfg_reg.low_threshold   <= '0;
            cfg_reg.high_threshold  <= PIX_W'(PIX_MAX);
            cfg_reg.coef_row_top    <= '0;
            cfg_reg.coef_row_mid    <= COEF_ROW_W'(1) << COEF_W;
            cfg_reg.coef_row_bottom <= '0;
            cfg_reg.divisor         <= DIV_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign valid_next = {valid_reg[CONV_DEPTH-1:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg    <= valid_next;
            m_tvalid_reg <= valid_reg[CONV_DEPTH];
        end
    end

    emk_conv u_conv (
        .clk (clk),
        .en  (en),
        .win (win_reg),
        .cfg (cfg_reg),
        .mag (conv_mag)
    );

    emk_fixed u_fixed (
        .clk  (clk),
        .en   (en),
        .win  (win_reg),
        .mode (cfg_reg.mode),
        .mag  (fixed_mag)
    );

    // Low test first: a magnitude at or below low gives zero even when low exceeds high.
    always_comb
    begin
        sel_mag = (cfg_reg.mode == MODE_CONV) ? conv_mag : fix_dly_reg[FIX_DLY-1];
        if (sel_mag <= {1'b0, cfg_reg.low_threshold})
        begin
            m_tdata_next = '0;
        end
        else if (sel_mag > {1'b0, cfg_reg.high_threshold})
        begin
            m_tdata_next = PIX_W'(PIX_MAX);
        end
        else
        begin
            m_tdata_next = sel_mag[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            win_reg        <= s_tdata;
            fix_dly_reg[0] <= fixed_mag;
            for (int i = 1; i < FIX_DLY; i++)
            begin
                fix_dly_reg[i] <= fix_dly_reg[i-1];
            end
            m_tdata_reg    <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/emk_conv.sv
// Convolution path: nine products, adder tree, magnitude and a pipelined divider.
`timescale 1ns / 1ps

module emk_conv
    import emk_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  win_t             win,
    input  cfg_t             cfg,
    output logic [MAG_W-1:0] mag
);

    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + 2;
    localparam int SUM_W  = ROW_W + 2;
    localparam int NUM_W  = SUM_W - 1;
    localparam int REM_W  = DIV_W + QUO_BITS;

    logic [2:0][COEF_ROW_W-1:0] rows;

    logic signed [PROD_W-1:0] prod_next [NUM_PIX];
    logic signed [PROD_W-1:0] prod_reg  [NUM_PIX];
    logic signed [ROW_W-1:0]  row_next  [3];
    logic signed [ROW_W-1:0]  row_reg   [3];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;

    logic [SUM_W-1:0] sum_abs;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] dabs;

    logic [REM_W-1:0]    rem_next [QUO_BITS+1];
    logic [REM_W-1:0]    rem_reg  [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_next   [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg    [QUO_BITS+1];
    logic                sat_next [QUO_BITS+1];
    logic                sat_reg  [QUO_BITS+1];

    assign rows = {cfg.coef_row_bottom, cfg.coef_row_mid, cfg.coef_row_top};
    assign dabs = cfg.divisor[DIV_W-1] ? DIV_W'(-cfg.divisor) : DIV_W'(cfg.divisor);

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            assign prod_next[3*r+c] = $signed({1'b0, win[3*r+c]})
                                    * $signed(rows[r][COEF_W*c +: COEF_W]);
        end
        assign row_next[r] = ROW_W'(prod_reg[3*r]) + ROW_W'(prod_reg[3*r+1])
                           + ROW_W'(prod_reg[3*r+2]);
    end

    assign sum_next = SUM_W'(row_reg[0]) + SUM_W'(row_reg[1]) + SUM_W'(row_reg[2]);

    // The sum magnitude stays far below the top bit, so one bit can be dropped.
    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num     = sum_abs[NUM_W-1:0];

    // A quotient of 256 or more always clips to full scale, so only the low
    // eight quotient bits are worked out, one per stage.
    assign rem_next[0] = num[REM_W-1:0];
    assign q_next[0]   = '0;
    assign sat_next[0] = num >= NUM_W'({dabs, {QUO_BITS{1'b0}}});

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        localparam int K = QUO_BITS - 1 - i;
        logic [REM_W-1:0] shd;
        logic             ge;

        assign shd           = REM_W'(dabs) << K;
        assign ge            = rem_reg[i] >= shd;
        assign rem_next[i+1] = ge ? rem_reg[i] - shd : rem_reg[i];
        assign q_next[i+1]   = {q_reg[i][QUO_BITS-2:0], ge};
        assign sat_next[i+1] = sat_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            row_reg  <= row_next;
            sum_reg  <= sum_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            sat_reg  <= sat_next;
        end
    end

    // A zero divisor gives zero.
    assign mag = (dabs == '0)           ? '0      :
                 sat_reg[QUO_BITS]      ? MAG_SAT :
                 {1'b0, q_reg[QUO_BITS]};

endmodule

>>> hdl/emk_fixed.sv
// Fixed operators: sobel, roberts, laplace, morpho, cartoon and both prewitt forms.
`timescale 1ns / 1ps

module emk_fixed
    import emk_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  win_t              win,
    input  logic [MODE_W-1:0] mode,
    output logic [MAG_W-1:0]  mag
);

    localparam int TERM_W = 12;
    localparam int ABS_W  = TERM_W - 1;

    function automatic logic [ABS_W-1:0] abs_term(input logic signed [TERM_W-1:0] v);
        logic signed [TERM_W-1:0] n;
        n = -v;
        return v[TERM_W-1] ? n[ABS_W-1:0] : v[ABS_W-1:0];
    endfunction

    function automatic logic [ABS_W-1:0] max_abs(input logic [ABS_W-1:0] a,
                                                 input logic [ABS_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] min_pix(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max_pix(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic signed [TERM_W-1:0] px [NUM_PIX];

    // First stage: signed terms and per-row extremes.
    logic signed [TERM_W-1:0] sobel_next, sobel_reg;
    logic signed [TERM_W-1:0] rob_next, rob_reg;
    logic signed [TERM_W-1:0] lap_next, lap_reg;
    logic signed [TERM_W-1:0] cart_next, cart_reg;
    logic signed [TERM_W-1:0] pw_next [4];
    logic signed [TERM_W-1:0] pw_reg  [4];
    logic signed [TERM_W-1:0] hp_next [2];
    logic signed [TERM_W-1:0] hp_reg  [2];
    logic [PIX_W-1:0]         rmin_next [3];
    logic [PIX_W-1:0]         rmin_reg  [3];
    logic [PIX_W-1:0]         rmax_next [3];
    logic [PIX_W-1:0]         rmax_reg  [3];

    // Second stage: magnitudes.
    logic [ABS_W-1:0] sobel_abs_next, sobel_abs_reg;
    logic [ABS_W-1:0] rob_abs_next, rob_abs_reg;
    logic [ABS_W-1:0] lap_abs_next, lap_abs_reg;
    logic [ABS_W-1:0] cart_abs_next, cart_abs_reg;
    logic             cart_pos_next, cart_pos_reg;
    logic [ABS_W-1:0] pw_abs_next [4];
    logic [ABS_W-1:0] pw_abs_reg  [4];
    logic [ABS_W-1:0] hp_abs_next [2];
    logic [ABS_W-1:0] hp_abs_reg  [2];
    logic [PIX_W-1:0] morph_next, morph_reg;

    // Third stage: selected and clipped magnitude.
    logic [ABS_W-1:0] sel;
    logic [MAG_W-1:0] mag_next, mag_reg;

    for (genvar k = 0; k < NUM_PIX; k++)
    begin : g_px
        assign px[k] = $signed({{(TERM_W-PIX_W){1'b0}}, win[k]});
    end

    always_comb
    begin
        sobel_next = px[5] + px[7] - px[3] - px[1];
        rob_next   = px[4] + px[4] - px[5] - px[7];
        lap_next   = (px[4] <<< 3) - ((px[0] + px[1] + px[2]) + (px[3] + px[5])
                                      + (px[6] + px[7] + px[8]));
        cart_next  = px[1] + px[1] - px[4] - px[2];
        pw_next[0] = px[0] + px[1] + px[2] - px[6] - px[7] - px[8];
        pw_next[1] = px[0] + px[3] + px[6] - px[2] - px[5] - px[8];
        pw_next[2] = px[3] + px[0] + px[1] - px[8] - px[5] - px[7];
        pw_next[3] = px[6] + px[3] + px[7] - px[2] - px[5] - px[1];
        hp_next[0] = px[0] + px[1] + px[1] + px[2] - px[6] - px[7] - px[7] - px[8];
        hp_next[1] = px[0] + px[3] + px[3] + px[6] - px[2] - px[5] - px[5] - px[8];
        for (int r = 0; r < 3; r++)
        begin
            rmin_next[r] = min_pix(min_pix(win[3*r], win[3*r+1]), win[3*r+2]);
            rmax_next[r] = max_pix(max_pix(win[3*r], win[3*r+1]), win[3*r+2]);
        end
    end

    always_comb
    begin
        sobel_abs_next = abs_term(sobel_reg);
        rob_abs_next   = abs_term(rob_reg);
        lap_abs_next   = abs_term(lap_reg);
        cart_abs_next  = abs_term(cart_reg);
        cart_pos_next  = !cart_reg[TERM_W-1] && (cart_reg != '0);
        for (int j = 0; j < 4; j++)
        begin
            pw_abs_next[j] = abs_term(pw_reg[j]);
        end
        for (int j = 0; j < 2; j++)
        begin
            hp_abs_next[j] = abs_term(hp_reg[j]);
        end
        morph_next = max_pix(max_pix(rmax_reg[0], rmax_reg[1]), rmax_reg[2])
                   - min_pix(min_pix(rmin_reg[0], rmin_reg[1]), rmin_reg[2]);
    end

    always_comb
    begin
        case (mode)
            MODE_SOBEL:        sel = sobel_abs_reg >> 1;
            MODE_ROBERTS:      sel = rob_abs_reg >> 1;
            MODE_LAPLACE:      sel = lap_abs_reg >> 3;
            MODE_MORPHO:       sel = ABS_W'(morph_reg);
            // A positive cartoon term gives zero, which every threshold maps to zero.
            MODE_CARTOON:      sel = cart_pos_reg ? '0 : cart_abs_reg;
            MODE_PREWITT:      sel = max_abs(max_abs(pw_abs_reg[0], pw_abs_reg[1]),
                                             max_abs(pw_abs_reg[2], pw_abs_reg[3]));
            MODE_HALF_PREWITT: sel = max_abs(hp_abs_reg[0], hp_abs_reg[1]);
            default:           sel = '0;
        endcase
        mag_next = (sel > ABS_W'(PIX_MAX)) ? MAG_SAT : MAG_W'(sel);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sobel_reg     <= sobel_next;
            rob_reg       <= rob_next;
            lap_reg       <= lap_next;
            cart_reg      <= cart_next;
            pw_reg        <= pw_next;
            hp_reg        <= hp_next;
            rmin_reg      <= rmin_next;
            rmax_reg      <= rmax_next;
            sobel_abs_reg <= sobel_abs_next;
            rob_abs_reg   <= rob_abs_next;
            lap_abs_reg   <= lap_abs_next;
            cart_abs_reg  <= cart_abs_next;
            cart_pos_reg  <= cart_pos_next;
            pw_abs_reg    <= pw_abs_next;
            hp_abs_reg    <= hp_abs_next;
            morph_reg     <= morph_next;
            mag_reg       <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

>>> tb/tb_edge_mask_3x3_core.sv
// Self-checking stream testbench for the 3x3 edge mask core with random flow control.
`timescale 1ns / 1ps

module tb_edge_mask_3x3_core;
    import emk_pkg::*;

    localparam int LATENCY      = 14;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_WAIT     = 14;
    localparam int MAX_REPORTS  = 200;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 75;

    localparam win_t WIN_CHECKER    = 72'hFF00FF00FF00FF00FF;
    localparam win_t WIN_SOBEL_EDGE = 72'h00FF00FF0000000000;
    localparam win_t WIN_BUMP       = 72'h323232329632323232;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [NUM_PIX*PIX_W-1:0] s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [PIX_W-1:0]         m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [2:0]               cfg_index = '0;
    logic [COEF_ROW_W-1:0]    cfg_data  = '0;

    cfg_t             cfg_model;
    win_t             window_queue[$];
    logic [PIX_W-1:0] mask_expected[$];
    int               windows_queued  = 0;
    int               windows_done    = 0;
    int               mismatch_count  = 0;
    int               send_wait       = 0;
    int               recv_wait       = 0;
    int               hold_off        = 0;
    bit               long_stall_done = 1'b0;
    bit               idle_on         = 1'b1;

    edge_mask_3x3_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
    endfunction

    function automatic logic [COEF_ROW_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic longint abs_val(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // The low test comes first, so it wins when low_threshold is above high_threshold.
    function automatic logic [PIX_W-1:0] apply_thresholds(input cfg_t c, input longint m);
        if (m <= longint'(c.low_threshold))
            return '0;
        if (m > longint'(c.high_threshold))
            return 8'd255;
        return m[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] predict_mask(input cfg_t c, input win_t w);
        longint                p [NUM_PIX];
        logic [COEF_ROW_W-1:0] rows [3];
        longint                acc;
        longint                dv;
        longint                d90;
        longint                d180;
        longint                d45;
        longint                d135;
        longint                lo;
        longint                hi;
        for (int k = 0; k < NUM_PIX; k++)
            p[k] = longint'(w[k]);
        rows[0] = c.coef_row_top;
        rows[1] = c.coef_row_mid;
        rows[2] = c.coef_row_bottom;
        case (c.mode)
            MODE_CONV:
            begin
                acc = 0;
                for (int r = 0; r < 3; r++)
                    for (int k = 0; k < 3; k++)
                        acc += p[3*r + k] * longint'($signed(rows[r][16*k +: 16]));
                dv = longint'($signed(c.divisor));
                if (dv == 0)
                    return '0;
                return apply_thresholds(c, abs_val(acc / dv));
            end
            MODE_SOBEL:
                return apply_thresholds(c, abs_val(p[5] + p[7] - p[3] - p[1]) >> 1);
            MODE_ROBERTS:
                return apply_thresholds(c, abs_val(2*p[4] - p[5] - p[7]) >> 1);
            MODE_LAPLACE:
            begin
                acc = 8 * p[4];
                for (int k = 0; k < NUM_PIX; k++)
                    if (k != 4)
                        acc -= p[k];
                return apply_thresholds(c, abs_val(acc) >> 3);
            end
            MODE_MORPHO:
            begin
                lo = p[0];
                hi = p[0];
                for (int k = 1; k < NUM_PIX; k++)
                begin
                    if (p[k] < lo) lo = p[k];
                    if (p[k] > hi) hi = p[k];
                end
                return apply_thresholds(c, hi - lo);
            end
            MODE_CARTOON:
            begin
                acc = 2*p[1] - p[4] - p[2];
                return (acc > 0) ? '0 : apply_thresholds(c, -acc);
            end
            MODE_PREWITT:
            begin
                d90  = abs_val(p[0] + p[1] + p[2] - p[6] - p[7] - p[8]);
                d180 = abs_val(p[0] + p[3] + p[6] - p[2] - p[5] - p[8]);
                d45  = abs_val(p[3] + p[0] + p[1] - p[8] - p[5] - p[7]);
                d135 = abs_val(p[6] + p[3] + p[7] - p[2] - p[5] - p[1]);
                hi = d90;
                if (d180 > hi) hi = d180;
                if (d45 > hi)  hi = d45;
                if (d135 > hi) hi = d135;
                return apply_thresholds(c, hi);
            end
            default:
            begin
                d90  = abs_val(p[0] + 2*p[1] + p[2] - p[6] - 2*p[7] - p[8]);
                d180 = abs_val(p[0] + 2*p[3] + p[6] - p[2] - 2*p[5] - p[8]);
                return apply_thresholds(c, (d180 > d90) ? d180 : d90);
            end
        endcase
    endfunction

    // Mix of plain noise, hard black/white edges and low-contrast patches, so that
    // magnitudes land below, between and above the thresholds.
    function automatic win_t random_window();
        win_t w;
        int   style;
        int   base;
        int   spread;
        int   v;
        style  = $urandom_range(0, 3);
        base   = $urandom_range(0, 255);
        spread = $urandom_range(1, 64);
        for (int k = 0; k < NUM_PIX; k++)
        begin
            case (style)
                0: w[k] = 8'($urandom);
                1: w[k] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default:
                begin
                    v = base + int'($urandom_range(0, 2*spread)) - spread;
                    if (v < 0)   v = 0;
                    if (v > 255) v = 255;
                    w[k] = 8'(v);
                end
            endcase
        end
        return w;
    endfunction

    function automatic logic [COEF_ROW_W-1:0] random_coef_row(input int style);
        logic [COEF_ROW_W-1:0] row;
        int                    c;
        for (int k = 0; k < 3; k++)
        begin
            case (style)
                0: c = int'($urandom_range(0, 4)) - 2;
                1: c = int'($urandom_range(0, 16)) - 8;
                2: c = int'($urandom);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       c = -32768;
                        1:       c = 32767;
                        default: c = -1;
                    endcase
                end
            endcase
            row[16*k +: 16] = 16'(c);
        end
        return row;
    endfunction

    // Called right after a rising edge; leaves cfg_valid high so back-to-back writes
    // follow one another with no idle gap. finish_phase drops it.
    task automatic write_reg(input reg_index_t idx, input logic [COEF_ROW_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MODE:           cfg_model.mode            = value[MODE_W-1:0];
            REG_LOW_THRESHOLD:  cfg_model.low_threshold   = value[PIX_W-1:0];
            REG_HIGH_THRESHOLD: cfg_model.high_threshold  = value[PIX_W-1:0];
            REG_COEF_TOP:       cfg_model.coef_row_top    = value;
            REG_COEF_MID:       cfg_model.coef_row_mid    = value;
            REG_COEF_BOTTOM:    cfg_model.coef_row_bottom = value;
            REG_DIVISOR:        cfg_model.divisor         = value[DIV_W-1:0];
            default:            ;
        endcase
    endtask

    task automatic add_window(input win_t w);
        window_queue.push_back(w);
        windows_queued++;
    endtask

    task automatic finish_phase();
        cfg_valid <= 1'b0;
        while (windows_done != windows_queued)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : driver
        logic need_next;
        if (rst_n)
        begin
            need_next = !s_tvalid;
            if (s_tvalid && s_tready)
            begin
                mask_expected.push_back(predict_mask(cfg_model, win_t'(s_tdata)));
                need_next = 1'b1;
            end
            if (need_next)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (window_queue.size() != 0)
                begin
                    s_tdata   <= window_queue.pop_front();
                    s_tvalid  <= 1'b1;
                    send_wait = draw_wait();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        logic [PIX_W-1:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (mask_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mask_value beat, expected none, got %0d",
                                 $time, m_tdata);
                end
                else
                begin
                    want = mask_expected.pop_front();
                    windows_done++;
                    if (m_tdata !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mask_value mismatch, expected %0d, got %0d",
                                     $time, want, m_tdata);
                    end
                end
                recv_wait = draw_wait();
            end
            // One long hold-off while plenty of windows are still waiting, so the
            // pipeline fills and has to push back on its input.
            if (!long_stall_done && window_queue.size() >= 60)
            begin
                long_stall_done = 1'b1;
                hold_off        = 300;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [COEF_ROW_W-1:0] v;
        int                    lo;
        int                    hi;
        int                    d;
        int                    kernel_style;
        cfg_model.mode            = MODE_SOBEL;
        cfg_model.low_threshold   = 8'd0;
        cfg_model.high_threshold  = 8'd255;
        cfg_model.coef_row_top    = '0;
        cfg_model.coef_row_mid    = 48'h0000_0001_0000;
        cfg_model.coef_row_bottom = '0;
        cfg_model.divisor         = 16'sd1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: sobel with pass-through thresholds.
        add_window('0);
        add_window(WIN_SOBEL_EDGE);
        finish_phase();

        for (int m = 0; m < 8; m++)
        begin
            write_reg(REG_MODE, COEF_ROW_W'(m));
            add_window(WIN_CHECKER);
            add_window(random_window());
            finish_phase();
        end

        // Extreme coefficients; the sums go far beyond 255 and must saturate.
        write_reg(REG_MODE, COEF_ROW_W'(MODE_CONV));
        write_reg(REG_COEF_TOP, {3{16'h8000}});
        write_reg(REG_COEF_MID, {3{16'h7FFF}});
        write_reg(REG_COEF_BOTTOM, {16'h8000, 16'h7FFF, 16'hFFFF});
        write_reg(REG_DIVISOR, 48'h0000_0000_FFFF);
        add_window('1);
        add_window(WIN_CHECKER);
        finish_phase();

        write_reg(REG_DIVISOR, 48'h0000_0000_8000);
        add_window(WIN_CHECKER);
        finish_phase();

        // A zero divisor forces 0 whatever the sum.
        write_reg(REG_DIVISOR, '0);
        add_window(WIN_CHECKER);
        finish_phase();

        // Low threshold above high threshold.
        write_reg(REG_MODE, COEF_ROW_W'(MODE_MORPHO));
        write_reg(REG_LOW_THRESHOLD, 48'd200);
        write_reg(REG_HIGH_THRESHOLD, 48'd10);
        add_window(WIN_BUMP);
        add_window(WIN_CHECKER);
        finish_phase();

        // Junk above each register's width is dropped, and index 7 has nothing behind it.
        write_reg(REG_MODE, '1);
        write_reg(REG_LOW_THRESHOLD, {40'hA5A5A5A5A5, 8'h00});
        write_reg(REG_HIGH_THRESHOLD, {40'h5A5A5A5A5A, 8'hFF});
        write_reg(REG_NONE, rand48());
        add_window(random_window());
        finish_phase();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            write_reg(REG_MODE, rand48());

            case ($urandom_range(0, 3))
                0, 1:
                begin
                    lo = 0;
                    hi = 255;
                end
                2:
                begin
                    lo = $urandom_range(0, 127);
                    hi = $urandom_range(lo, 255);
                end
                default:
                begin
                    lo = $urandom_range(0, 255);
                    hi = $urandom_range(0, 255);
                end
            endcase
            v = rand48();
            v[PIX_W-1:0] = 8'(lo);
            write_reg(REG_LOW_THRESHOLD, v);
            v = rand48();
            v[PIX_W-1:0] = 8'(hi);
            write_reg(REG_HIGH_THRESHOLD, v);

            kernel_style = ($urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 3);
            for (int r = 0; r < 3; r++)
                write_reg(reg_index_t'(int'(REG_COEF_TOP) + r), random_coef_row(kernel_style));

            v = rand48();
            case ($urandom_range(0, 9))
                0:    v[DIV_W-1:0] = '0;
                1:    v[DIV_W-1:0] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
                2, 3: ;
                default:
                begin
                    d = $urandom_range(1, 16);
                    v[DIV_W-1:0] = ($urandom_range(0, 1) != 0) ? 16'(-d) : 16'(d);
                end
            endcase
            write_reg(REG_DIVISOR, v);

            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, rand48());

            for (int n = 0; n < PHASE_ITEMS; n++)
                add_window(random_window());
            finish_phase();
        end

        repeat (4 * LATENCY) @(posedge clk);
        if (mismatch_count == 0 && mask_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/emk_pkg.sv
hdl/emk_conv.sv
hdl/emk_fixed.sv
hdl/edge_mask_3x3_core.sv
tb/tb_edge_mask_3x3_core.sv
